>>> rtl/glcm_pkg.sv
// Shared constants, transaction types and helper functions of the co-occurrence histogram.
`default_nettype none
package glcm_pkg;

  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned MAX_LEVEL_BITS = 8;
  localparam int unsigned COUNT_BITS     = 32;

  localparam int unsigned HIST_AW    = 2 * MAX_LEVEL_BITS;
  localparam int unsigned HIST_DEPTH = 1 << HIST_AW;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned NUM_SLOTS  = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DIR_MASK   = 2'd0,
    REG_LEVEL_BITS = 2'd1,
    REG_IMG_WIDTH  = 2'd2,
    REG_NONE       = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pixel_value;
    logic [7:0] bin_row;
    logic [7:0] bin_col;
  } in_item_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] total_pairs;
    logic [31:0] bin_fraction;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [COUNT_BITS-1:0] num;
    logic [COUNT_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  // Saturate an internal count to the 32-bit result field.
  function automatic logic [31:0] sat_out(logic [COUNT_BITS-1:0] cnt);
    logic [COUNT_BITS+31:0] ext;
    ext = {32'd0, cnt};
    if (ext[COUNT_BITS+31:32] != '0) begin
      return 32'hFFFF_FFFF;
    end
    return ext[31:0];
  endfunction

  // Quantize a raw pixel by a right shift.
  function automatic logic [MAX_LEVEL_BITS-1:0] quant(logic [7:0] raw, logic [3:0] sh);
    logic [7:0] v;
    v = raw >> sh;
    return v[MAX_LEVEL_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/glcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module glcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/glcm_divider.sv
// Bit-serial restoring divider producing count/total as unsigned Q1.31.
`default_nettype none
module glcm_divider (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire glcm_pkg::div_req_t  req_i,
  output glcm_pkg::div_rsp_t       rsp_o
);

  localparam int unsigned CB = glcm_pkg::COUNT_BITS;

  logic          busy_q, done_q, zero_q;
  logic [4:0]    step_q;
  logic [CB:0]   rem_q;
  logic [CB-1:0] den_q;
  logic [31:0]   quot_q;

  logic [CB-1:0] num_c;
  logic [CB:0]   rem_sh;
  logic          init_ge, step_ge;

  always_comb begin
    num_c   = (req_i.num > req_i.den) ? req_i.den : req_i.num;
    init_ge = (num_c == req_i.den);
    rem_sh  = {rem_q[CB-1:0], 1'b0};
    step_ge = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      zero_q <= 1'b0;
      rem_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        den_q  <= req_i.den;
        zero_q <= (req_i.den == '0);
        rem_q  <= init_ge ? '0 : {1'b0, num_c};
        quot_q <= {31'd0, init_ge};
      end else if (busy_q) begin
        rem_q  <= step_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quot_q <= {quot_q[30:0], step_ge};
        step_q <= step_q + 5'd1;
        if (step_q == 5'd30) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = zero_q ? 32'd0 : quot_q;

endmodule
`default_nettype wire

>>> rtl/glcm_cooccurrence_histogram.sv
// Top level: gray-level co-occurrence histogram with line buffer, bin memory and APB registers.
// Usage:
// - Input channel (in_valid_i/in_ready_o, in_data_i) carries one command per transaction:
//   clear, pixel (raster order) or read bin. Output channel (out_valid_o/out_ready_i,
//   out_data_o) carries one transaction per read-bin command only.
// - A pixel reads its north and northeast neighbors, then walks the pair slots, passing
//   skipped ones; each enabled, in-image pair is a read-modify-write of the single bin memory.
// - A read goes through the bin memory read, then a one-bit-per-cycle divider for the
//   Q1.31 fraction, before out_valid_o rises. The result sits in an output register.
// - A clear sweeps the bin memory one entry per cycle.
// - After reset the same clearing pass runs, in_ready_o low until it ends; pready always high.
//   The user writes registers over APB between transactions; the block does not enforce it.
// - If the receiver stalls, the result waits in the output register and further
//   pixels and clears are still taken; a second read waits until the first is taken.
// - Counts and the pair total saturate at all ones.
`default_nettype none
module glcm_cooccurrence_histogram (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire glcm_pkg::in_item_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output glcm_pkg::out_item_t                    out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [glcm_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int unsigned MLB = glcm_pkg::MAX_LEVEL_BITS;
  localparam int unsigned CB  = glcm_pkg::COUNT_BITS;
  localparam int unsigned HAW = glcm_pkg::HIST_AW;
  localparam int unsigned CW  = glcm_pkg::COL_W;
  localparam int unsigned WW  = glcm_pkg::WID_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_NORTH = 9'b000000100,
    S_NEAST = 9'b000001000,
    S_SLOT  = 9'b000010000,
    S_BUMP  = 9'b000100000,
    S_HREAD = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // ---------------- configuration registers ----------------
  logic [7:0]  dir_q;
  logic [3:0]  lb_q;
  logic [10:0] img_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 8'd4;
      lb_q  <= 4'd8;
      img_q <= 11'd1024;
    end else if (cfg_we) begin
      case (glcm_pkg::reg_e'(paddr[3:2]))
        glcm_pkg::REG_DIR_MASK:   dir_q <= pwdata[7:0];
        glcm_pkg::REG_LEVEL_BITS: lb_q  <= pwdata[3:0];
        glcm_pkg::REG_IMG_WIDTH:  img_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (glcm_pkg::reg_e'(paddr[3:2]))
      glcm_pkg::REG_DIR_MASK:   prdata = {24'd0, dir_q};
      glcm_pkg::REG_LEVEL_BITS: prdata = {28'd0, lb_q};
      glcm_pkg::REG_IMG_WIDTH:  prdata = {21'd0, img_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // Clamped settings.
  logic [3:0]    lb_eff, shift;
  logic [31:0]   img32;
  logic [WW-1:0] width_eff;

  always_comb begin
    if (lb_q < 4'd2) begin
      lb_eff = 4'd2;
    end else if (lb_q > 4'(MLB)) begin
      lb_eff = 4'(MLB);
    end else begin
      lb_eff = lb_q;
    end
    shift = 4'd8 - lb_eff;
    img32 = 32'(img_q);
    if (img_q == '0) begin
      width_eff = WW'(1);
    end else if (img32 > 32'(glcm_pkg::MAX_WIDTH)) begin
      width_eff = WW'(glcm_pkg::MAX_WIDTH);
    end else begin
      width_eff = WW'(img32);
    end
  end

  // ---------------- raster position and neighbors ----------------
  logic [CW-1:0] col_q;
  logic          first_q;
  logic [7:0]    left_q, diag_q, raw_q, north_q, ne_q;
  logic [WW-1:0] x1;
  logic          row_end;

  assign x1      = WW'(col_q) + WW'(1);
  assign row_end = (x1 >= width_eff);

  // Line store: previous row, raw pixels.
  logic          line_we;
  logic [CW-1:0] line_raddr;
  logic [7:0]    line_rdata;

  assign line_we    = (state_q == S_NEAST);
  assign line_raddr = (state_q == S_IDLE) ? col_q :
                      ((x1 < WW'(glcm_pkg::MAX_WIDTH)) ? CW'(x1) : '0);

  glcm_ram #(
    .WIDTH (8),
    .DEPTH (glcm_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (col_q),
    .wdata_i (raw_q),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // ---------------- pair slots ----------------
  // Slot order: west, east, north, south, northwest, southeast, northeast, southwest.
  logic [MLB-1:0] cq, wq, nq, dq, eq;
  logic [2:0]     slot_q;
  logic [7:0]     slot_en;
  logic [MLB-1:0] ref_lvl, nb_lvl;
  logic           x_ok, n_ok;

  always_comb begin
    cq   = glcm_pkg::quant(raw_q, shift);
    wq   = glcm_pkg::quant(left_q, shift);
    nq   = glcm_pkg::quant(north_q, shift);
    dq   = glcm_pkg::quant(diag_q, shift);
    eq   = glcm_pkg::quant(ne_q, shift);
    x_ok = (col_q != '0);
    n_ok = !first_q;
    slot_en[0] = dir_q[3] && x_ok;
    slot_en[1] = dir_q[2] && x_ok;
    slot_en[2] = dir_q[0] && n_ok;
    slot_en[3] = dir_q[1] && n_ok;
    slot_en[4] = dir_q[5] && n_ok && x_ok;
    slot_en[5] = dir_q[6] && n_ok && x_ok;
    slot_en[6] = dir_q[4] && n_ok && !row_end;
    slot_en[7] = dir_q[7] && n_ok && !row_end;
    case (slot_q)
      3'd0:    begin ref_lvl = cq; nb_lvl = wq; end
      3'd1:    begin ref_lvl = wq; nb_lvl = cq; end
      3'd2:    begin ref_lvl = cq; nb_lvl = nq; end
      3'd3:    begin ref_lvl = nq; nb_lvl = cq; end
      3'd4:    begin ref_lvl = cq; nb_lvl = dq; end
      3'd5:    begin ref_lvl = dq; nb_lvl = cq; end
      3'd6:    begin ref_lvl = cq; nb_lvl = eq; end
      default: begin ref_lvl = eq; nb_lvl = cq; end
    endcase
  end

  // ---------------- histogram memory ----------------
  logic [HAW-1:0] clr_q, haddr_q, hist_raddr, hist_waddr;
  logic [CB-1:0]  hist_rdata, hist_wdata, total_q, cnt_q;
  logic           hist_we, oor;

  assign oor = ((in_data_i.bin_row >> MLB) != 8'd0) || ((in_data_i.bin_col >> MLB) != 8'd0);

  always_comb begin
    case (state_q)
      S_IDLE:  hist_raddr = {in_data_i.bin_row[MLB-1:0], in_data_i.bin_col[MLB-1:0]};
      S_SLOT:  hist_raddr = {ref_lvl, nb_lvl};
      default: hist_raddr = clr_q;
    endcase
    hist_we    = (state_q == S_CLEAR) || (state_q == S_BUMP);
    hist_waddr = (state_q == S_CLEAR) ? clr_q : haddr_q;
    if (state_q == S_CLEAR) begin
      hist_wdata = '0;
    end else begin
      hist_wdata = (hist_rdata == '1) ? hist_rdata : hist_rdata + CB'(1);
    end
  end

  glcm_ram #(
    .WIDTH (CB),
    .DEPTH (glcm_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // ---------------- fraction divider ----------------
  glcm_pkg::div_req_t div_req;
  glcm_pkg::div_rsp_t div_rsp;
  logic               oor_q;

  assign div_req.start = (state_q == S_HREAD);
  assign div_req.num   = oor_q ? '0 : hist_rdata;
  assign div_req.den   = total_q;

  glcm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- sequencer ----------------
  logic        in_acc, out_free, slot_last;
  logic [31:0] frac_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign slot_last  = (slot_q == 3'(glcm_pkg::NUM_SLOTS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (glcm_pkg::cmd_e'(in_data_i.cmd))
            glcm_pkg::CMD_CLEAR: state_d = S_CLEAR;
            glcm_pkg::CMD_PIXEL: state_d = S_NORTH;
            glcm_pkg::CMD_READ:  state_d = S_HREAD;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_NORTH: state_d = S_NEAST;
      S_NEAST: state_d = S_SLOT;
      S_SLOT: begin
        if (slot_en[slot_q]) begin
          state_d = S_BUMP;
        end else if (slot_last) begin
          state_d = S_IDLE;
        end
      end
      S_BUMP:  state_d = slot_last ? S_IDLE : S_SLOT;
      S_HREAD: state_d = S_DIV;
      S_DIV:   if (div_rsp.done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Pixel done: last slot left either by skip or by its write-back.
  logic pix_done;
  assign pix_done = ((state_q == S_SLOT) && !slot_en[slot_q] && slot_last) ||
                    ((state_q == S_BUMP) && slot_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      first_q     <= 1'b1;
      left_q      <= '0;
      diag_q      <= '0;
      total_q     <= '0;
      slot_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + HAW'(1);
      end
      if (in_acc && (glcm_pkg::cmd_e'(in_data_i.cmd) == glcm_pkg::CMD_CLEAR)) begin
        clr_q   <= '0;
        col_q   <= '0;
        first_q <= 1'b1;
        left_q  <= '0;
        diag_q  <= '0;
        total_q <= '0;
      end
      if (state_q == S_NEAST) begin
        slot_q <= '0;
      end else if ((state_q == S_SLOT) && !slot_en[slot_q]) begin
        slot_q <= slot_q + 3'd1;
      end else if (state_q == S_BUMP) begin
        slot_q <= slot_q + 3'd1;
        if (total_q != '1) begin
          total_q <= total_q + CB'(1);
        end
      end
      if (pix_done) begin
        if (row_end) begin
          col_q   <= '0;
          first_q <= 1'b0;
          left_q  <= '0;
          diag_q  <= '0;
        end else begin
          col_q  <= CW'(x1);
          left_q <= raw_q;
          diag_q <= north_q;
        end
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q <= in_data_i.pixel_value;
      oor_q <= oor;
    end
    if (state_q == S_NORTH) north_q <= line_rdata;
    if (state_q == S_NEAST) ne_q <= line_rdata;
    if (state_q == S_SLOT) haddr_q <= hist_raddr;
    if (state_q == S_HREAD) cnt_q <= div_req.num;
    if (div_rsp.done) frac_q <= div_rsp.quot;
    if ((state_q == S_OUT) && out_free) begin
      out_data_o.bin_count    <= glcm_pkg::sat_out(cnt_q);
      out_data_o.total_pairs  <= glcm_pkg::sat_out(total_q);
      out_data_o.bin_fraction <= frac_q;
    end
  end

  // ---------------- assertions ----------------
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hist_we) else $error("bin memory written while idle");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV)) else $error("divider finished outside a read");

  a_total_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_CLEAR) && ($past(state_q) != S_CLEAR)) |-> (total_q >= $past(total_q)))
    else $error("pair total decreased without a clear");

endmodule
`default_nettype wire
